@@ rtl/core/lzte_pkg.sv @@
package lzte_pkg;

   // sizes of the dictionary window and the lookahead buffer
   localparam int WIN_SIZE = 512;
   localparam int LA_SIZE  = 64;

   localparam int POS_W  = $clog2(WIN_SIZE);      // window index, match position
   localparam int SCAN_W = $clog2(WIN_SIZE + 1);  // scan counter, write count
   localparam int LEN_W  = $clog2(LA_SIZE);       // match length
   localparam int IDX_W  = $clog2(LA_SIZE);       // lookahead index
   localparam int CNT_W  = $clog2(LA_SIZE + 1);   // lookahead fill count

   localparam int SYM_W       = 8;
   localparam int RSP_BITS    = POS_W + LEN_W + SYM_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // queue between the front and the back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic             first;  // opens a new stream
      logic             last;   // closes the stream
      logic [SYM_W-1:0] data;
   } q_word_type;

endpackage

@@ rtl/core/lzte_front.sv @@
module lzte_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // data_byte
   input  logic                req_tlast,   // last_byte
   output logic                q_valid,
   output lzte_pkg::q_word_type q_word,
   input  logic                q_pop
);
   import lzte_pkg::*;

   q_word_type           q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   fill_ff, fill_in;
   logic                 started_ff, started_in;
   logic                 push;
   logic                 pop;

   assign req_tready = (fill_ff < Q_CNT_W'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_word     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      started_in = started_ff;
      if (push) begin
         wr_ptr_in  = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         started_in = !req_tlast;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= '{first: !started_ff, last: req_tlast, data: req_tdata};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
         started_ff <= started_in;
      end
   end

endmodule

@@ rtl/core/lzte_back.sv @@
module lzte_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  lzte_pkg::q_word_type             q_word,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lzte_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);
   import lzte_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FLUSH  = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_PICK   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;
   localparam logic [2:0] ST_SLIDE  = 3'd5;

   localparam logic KIND_DONE  = 1'b0;
   localparam logic KIND_SLIDE = 1'b1;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              flush_ff, flush_in;
   logic [POS_W-1:0]  head_ff, head_in;
   logic [SCAN_W-1:0] wc_ff, wc_in;
   logic [SYM_W-1:0]  first_ff, first_in;
   logic [SYM_W-1:0]  la_ff [LA_SIZE];
   logic [SYM_W-1:0]  la_in [LA_SIZE];
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [POS_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_written_ff;
   logic [SYM_W-1:0]  rd_data_ff;
   logic [LA_SIZE-1:0] run_ff, run_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [POS_W-1:0]  best_pos_ff, best_pos_in;
   logic [POS_W-1:0]  tok_pos_ff, tok_pos_in;
   logic [LEN_W-1:0]  tok_len_ff, tok_len_in;
   logic [SYM_W-1:0]  tok_sym_ff, tok_sym_in;
   logic              tok_last_ff, tok_last_in;
   logic              kind_ff, kind_in;
   logic [CNT_W-1:0]  slide_ff, slide_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [SYM_W-1:0]  win_mem [WIN_SIZE];
   logic              mem_we;
   logic [POS_W:0]    addr_sum;
   logic [POS_W-1:0]  rd_addr;
   logic [SYM_W-1:0]  win_byte;
   logic [LA_SIZE-1:0] run_next;
   logic              top_hit;
   logic [LEN_W-1:0]  top_k;
   logic [LEN_W-1:0]  top_len;
   logic [POS_W-1:0]  top_pos;

   assign addr_sum = {1'b0, head_ff} + {1'b0, scan_ff[POS_W-1:0]};
   assign rd_addr  = (addr_sum >= (POS_W+1)'(WIN_SIZE))
                     ? POS_W'(addr_sum - (POS_W+1)'(WIN_SIZE)) : addr_sum[POS_W-1:0];
   // entries not yet overwritten still hold the stream's first byte
   assign win_byte = rd_written_ff ? rd_data_ff : first_ff;

   // one lane per lookahead offset: run of matches ending at the current window byte
   always_comb begin
      run_next = '0;
      top_hit  = 1'b0;
      top_k    = '0;
      for (int k = 0; k < LA_SIZE; k++) begin
         if ((CNT_W'(k + 1) < count_ff) && (la_ff[k] == win_byte)) begin
            run_next[k] = (k == 0) ? 1'b1 : run_ff[(k == 0) ? 0 : k - 1];
         end
      end
      for (int k = 0; k < LA_SIZE; k++) begin
         if (run_next[k]) begin
            top_hit = 1'b1;
            top_k   = LEN_W'(k);
         end
      end
   end

   assign top_len = top_k + 1'b1;
   assign top_pos = rd_idx_ff - POS_W'(top_k);

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      flush_in     = flush_ff;
      head_in      = head_ff;
      wc_in        = wc_ff;
      first_in     = first_ff;
      la_in        = la_ff;
      scan_in      = scan_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      run_in       = run_ff;
      best_len_in  = best_len_ff;
      best_pos_in  = best_pos_ff;
      tok_pos_in   = tok_pos_ff;
      tok_len_in   = tok_len_ff;
      tok_sym_in   = tok_sym_ff;
      tok_last_in  = tok_last_ff;
      kind_in      = kind_ff;
      slide_in     = slide_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;

      if (rd_valid_ff) begin
         run_in = run_next;
         if (top_hit && (top_len > best_len_ff)) begin
            best_len_in = top_len;
            best_pos_in = top_pos;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_word.first) begin
                  first_in    = q_word.data;
                  wc_in       = '0;
                  head_in     = '0;
                  count_in    = '0;
                  flush_in    = 1'b0;
                  tok_pos_in  = '0;
                  tok_len_in  = '0;
                  tok_sym_in  = q_word.data;
                  tok_last_in = q_word.last;
                  kind_in     = KIND_DONE;
                  state_in    = ST_RESULT;
               end else begin
                  la_in[count_ff[IDX_W-1:0]] = q_word.data;
                  count_in = count_ff + 1'b1;
                  if (q_word.last) begin
                     flush_in = 1'b1;
                     state_in = ST_FLUSH;
                  end else if (count_ff == CNT_W'(LA_SIZE - 1)) begin
                     scan_in     = '0;
                     run_in      = '0;
                     best_len_in = '0;
                     best_pos_in = '0;
                     state_in    = ST_SEARCH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (count_ff > CNT_W'(1)) begin
               scan_in     = '0;
               run_in      = '0;
               best_len_in = '0;
               best_pos_in = '0;
               state_in    = ST_SEARCH;
            end else begin
               tok_pos_in  = '0;
               tok_len_in  = '0;
               tok_sym_in  = la_ff[0];
               tok_last_in = 1'b1;
               kind_in     = KIND_DONE;
               state_in    = ST_RESULT;
            end
         end
         ST_SEARCH: begin
            if (scan_ff < SCAN_W'(WIN_SIZE)) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_ff[POS_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            tok_pos_in  = best_pos_ff;
            tok_len_in  = best_len_ff;
            tok_sym_in  = la_ff[best_len_ff];
            tok_last_in = flush_ff && (count_ff == CNT_W'(best_len_ff) + 1'b1);
            kind_in     = KIND_SLIDE;
            slide_in    = CNT_W'(best_len_ff) + 1'b1;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({tok_sym_ff, tok_len_ff, tok_pos_ff});
               rsp_last_in  = tok_last_ff;
               if (kind_ff == KIND_SLIDE) begin
                  state_in = ST_SLIDE;
               end else begin
                  count_in = '0;
                  flush_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SLIDE: begin
            mem_we   = 1'b1;
            head_in  = (head_ff == POS_W'(WIN_SIZE - 1)) ? '0 : head_ff + 1'b1;
            wc_in    = (wc_ff == SCAN_W'(WIN_SIZE)) ? wc_ff : wc_ff + 1'b1;
            for (int k = 0; k < LA_SIZE - 1; k++) begin
               la_in[k] = la_ff[k + 1];
            end
            count_in = count_ff - 1'b1;
            slide_in = slide_ff - 1'b1;
            if (slide_ff == CNT_W'(1)) begin
               if (!flush_ff) begin
                  state_in = ST_IDLE;
               end else if (count_ff == CNT_W'(1)) begin
                  flush_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[head_ff] <= la_ff[0];
      end
      rd_data_ff <= win_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_written_ff <= ({1'b0, rd_addr} < wc_ff);
      first_ff      <= first_in;
      la_ff         <= la_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      run_ff        <= run_in;
      best_len_ff   <= best_len_in;
      best_pos_ff   <= best_pos_in;
      tok_pos_ff    <= tok_pos_in;
      tok_len_ff    <= tok_len_in;
      tok_sym_ff    <= tok_sym_in;
      tok_last_ff   <= tok_last_in;
      kind_ff       <= kind_in;
      slide_ff      <= slide_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         flush_ff     <= 1'b0;
         head_ff      <= '0;
         wc_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flush_ff     <= flush_in;
         head_ff      <= head_in;
         wc_ff        <= wc_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LA_SIZE))
      else $error("lookahead count above buffer size");

   a_search_avail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (count_ff > CNT_W'(1)))
      else $error("search started with fewer than two bytes");

   a_slide_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLIDE) |-> (slide_ff != '0) && (slide_ff <= count_ff))
      else $error("slide longer than the lookahead contents");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && state_ff == ST_RESULT) |=> (state_ff == ST_RESULT))
      else $error("triple left the result stage while output was stalled");
`endif

endmodule

@@ rtl/core/lz77_triple_encoder.sv @@
// lz77 triple encoder: bytes arrive on req_ (tlast marks the end of a stream) and
// triples (position, length, next symbol) leave on rsp_ (tlast on the final triple).
// the first byte of a stream seeds the whole 512-byte window and comes straight back
// as a literal; later bytes fill a 64-byte lookahead. a full lookahead, or the end
// of a stream with two or more bytes left, starts a search that walks the window
// one byte per cycle through its single read port; the block then slides the matched
// bytes and the next symbol into the window, with a hand-off (taking the byte, picking
// the best match, loading the result register); during the flush at the end of a
// stream each triple also passes through the flush state. a byte that does not
// complete the lookahead is absorbed. a four-word queue sits in front, so while it
// has room, bytes keep being taken while a search or a stalled result is pending.
module lz77_triple_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // data_byte[7:0]
   input  logic                             req_tlast,   // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // match_position[8:0], match_length[14:9], next_symbol[22:15], zero pad
   output logic [lzte_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast    // token_last
);
   import lzte_pkg::*;

   // front to back queue
   logic       q_valid;
   q_word_type q_word;
   logic       q_pop;

   // front: accepts bytes and tags the first one of each stream
   lzte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_word     (q_word),
      .q_pop      (q_pop)
   );

   // back: lookahead, window search, slide and result register
   lzte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_word     (q_word),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/tb_lz77_triple_encoder.sv @@
module tb_lz77_triple_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import lzte_pkg::*;

   // one input word: a byte and its end-of-stream flag
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_word_type;

   // one triple as the block should emit it
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] len;
      logic [7:0]       sym;
      logic             last;
   } triple_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // data_byte[7:0]
   logic                   req_tlast = 1'b0; // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // match_position[8:0], match_length[14:9], next_symbol[22:15], zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;        // token_last

   byte_word_type pending_bytes[$];
   triple_type    expected_triples[$];
   idle_mode_type idle_mode = IDLE_NONE;
   bit         sender_hold = 1'b0;   // sender offers nothing while set
   bit         long_hold_go = 1'b0;  // asks the receiver for one long hold-off
   bit         long_hold_taken = 1'b0;
   int         long_hold_left = 0;
   int         mismatches = 0;

   // encoder shadow state
   logic [7:0]       shadow_window[WIN_SIZE];
   logic [7:0]       shadow_lookahead[LA_SIZE];
   int               shadow_count = 0;
   logic [POS_W-1:0] shadow_head = '0;
   bit               shadow_started = 1'b0;

   lz77_triple_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #5 clock = ~clock;

   // append one byte to the stimulus queue
   function automatic void queue_byte(logic [7:0] data, logic last);
      byte_word_type w;
      w.data = data;
      w.last = last;
      pending_bytes = {pending_bytes, w};
   endfunction

   // append one triple to the expectations
   function automatic void expect_triple(triple_type t);
      expected_triples = {expected_triples, t};
   endfunction

   // one search over the first avail lookahead bytes, then slide the window
   function automatic void emit_match(int avail);
      int       best_pos;
      int       best_len;
      int       mlen;
      logic [7:0] best_sym;
      triple_type t;
      best_pos = 0;
      best_len = 0;
      best_sym = shadow_lookahead[0];
      for (int i = 0; i < WIN_SIZE; i++) begin
         if (shadow_window[(shadow_head + i) % WIN_SIZE] != shadow_lookahead[0]) continue;
         mlen = 1;
         while (i + mlen < WIN_SIZE && mlen + 1 < avail &&
                shadow_window[(shadow_head + i + mlen) % WIN_SIZE] == shadow_lookahead[mlen])
            mlen++;
         if (mlen > best_len) begin
            best_pos = i;
            best_len = mlen;
            best_sym = shadow_lookahead[mlen];
         end
      end
      t.pos  = best_pos[POS_W-1:0];
      t.len  = best_len[LEN_W-1:0];
      t.sym  = best_sym;
      t.last = 1'b0;
      expect_triple(t);
      for (int k = 0; k <= best_len; k++) begin
         shadow_window[shadow_head] = shadow_lookahead[k];
         shadow_head = shadow_head + 1'b1;
      end
      for (int k = 0; k < shadow_count - (best_len + 1); k++)
         shadow_lookahead[k] = shadow_lookahead[k + best_len + 1];
      shadow_count -= best_len + 1;
   endfunction

   // work out the triples that one accepted byte causes
   function automatic void encode_byte(byte_word_type w);
      triple_type t;
      int      avail;
      if (!shadow_started) begin
         // first byte seeds the whole window and comes back as a literal
         for (int i = 0; i < WIN_SIZE; i++) shadow_window[i] = w.data;
         shadow_head  = '0;
         shadow_count = 0;
         t = '{pos: '0, len: '0, sym: w.data, last: w.last};
         expect_triple(t);
         shadow_started = !w.last;
         return;
      end
      if (shadow_count < LA_SIZE) begin
         shadow_lookahead[shadow_count] = w.data;
         shadow_count++;
      end
      if (!w.last) begin
         if (shadow_count == LA_SIZE) emit_match(LA_SIZE);
         return;
      end
      // flush the lookahead at the end of the stream
      while (shadow_count > 1) begin
         avail = (shadow_count < LA_SIZE) ? shadow_count : LA_SIZE;
         emit_match(avail);
      end
      if (shadow_count == 1) begin
         t = '{pos: '0, len: '0, sym: shadow_lookahead[0], last: 1'b0};
         expect_triple(t);
      end
      expected_triples[expected_triples.size() - 1].last = 1'b1;
      shadow_count   = 0;
      shadow_head    = '0;
      shadow_started = 1'b0;
   endfunction

   // queue one stream; alphabet_span small gives long matches
   task automatic queue_stream(int n, int alphabet_span);
      logic [7:0] base;
      logic [7:0] d;
      base = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
         d = (alphabet_span >= 256) ? 8'($urandom_range(0, 255))
                                    : base + 8'($urandom_range(0, alphabet_span - 1));
         queue_byte(d, (i == n - 1));
      end
   endtask

   task automatic queue_random_streams(int budget);
      int n;
      int span;
      while (budget > 0) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 30);
         if (n > budget) n = budget;
         case ($urandom_range(0, 3))
            0: span = 1;
            1: span = 2;
            2: span = 4;
            default: span = 256;
         endcase
         queue_stream(n, span);
         budget -= n;
      end
   endtask

   task automatic drain_inputs();
      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   // sender: one word held until taken, next word picked from the queue
   always @(posedge clock) begin
      bit         taken;
      bit         idle_now;
      byte_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken) encode_byte('{data: req_tdata, last: req_tlast});
         if (!req_tvalid || taken) begin
            idle_now = (idle_mode == IDLE_SENDER) ? ($urandom_range(0, 99) < 49) :
                       (idle_mode == IDLE_BOTH)   ? ($urandom_range(0, 99) < 7) : 1'b0;
            if (pending_bytes.size() != 0 && !idle_now && !sender_hold) begin
               w = pending_bytes.pop_front();
               req_tdata  <= w.data;
               req_tlast  <= w.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (long_hold_go && !long_hold_taken) begin
         long_hold_left  <= 8000;
         long_hold_taken <= 1'b1;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // receiver: compare each taken triple with the oldest expectation
   always @(posedge clock) begin
      triple_type exp_t;
      bit      stall_now;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_triples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected triple: data %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               exp_t = expected_triples.pop_front();
               if (rsp_tdata[POS_W-1:0] !== exp_t.pos ||
                   rsp_tdata[POS_W+LEN_W-1:POS_W] !== exp_t.len ||
                   rsp_tdata[RSP_BITS-1:POS_W+LEN_W] !== exp_t.sym ||
                   rsp_tdata[RSP_TDATA_W-1:RSP_BITS] !== '0 ||
                   rsp_tlast !== exp_t.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("triple mismatch: expected pos %0d len %0d sym %h last %b,",
                              exp_t.pos, exp_t.len, exp_t.sym, exp_t.last,
                              " got pos %0d len %0d sym %h pad %b last %b",
                              rsp_tdata[POS_W-1:0], rsp_tdata[POS_W+LEN_W-1:POS_W],
                              rsp_tdata[RSP_BITS-1:POS_W+LEN_W],
                              rsp_tdata[RSP_TDATA_W-1:RSP_BITS], rsp_tlast);
               end
            end
         end
         stall_now = (idle_mode == IDLE_RECEIVER) ? ($urandom_range(0, 99) < 49) :
                     (idle_mode == IDLE_BOTH)     ? ($urandom_range(0, 99) < 7) : 1'b0;
         rsp_tready <= !(stall_now || long_hold_left > 0);
      end
   end

   // overall time limit
   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: lone last byte at both extremes, short flushes, repeats
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hAA, 1'b1);
      for (int i = 0; i < 8; i++) begin
         queue_byte(8'h01 << i, 1'b0);
      end
      queue_byte(8'hFE, 1'b1);
      for (int i = 0; i < 6; i++)
         queue_byte(8'h3C, (i == 5));
      drain_inputs();

      // sender pause until every triple is home
      sender_hold = 1'b1;
      while (expected_triples.size() != 0) @(posedge clock);
      sender_hold = 1'b0;

      // long receiver hold while a long stream keeps arriving
      long_hold_go = 1'b1;
      queue_stream(200, 256);
      queue_random_streams(30);
      drain_inputs();

      idle_mode = IDLE_SENDER;
      queue_random_streams(70);
      drain_inputs();
      idle_mode = IDLE_RECEIVER;
      queue_random_streams(70);
      drain_inputs();
      idle_mode = IDLE_BOTH;
      queue_random_streams(70);
      drain_inputs();

      idle_mode = IDLE_NONE;
      while (expected_triples.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (mismatches == 0 && expected_triples.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
